### design/teg_pkg.sv
// Package for the text encoding guesser: charset codes, byte constants,
// the per-message tracking state and its cleared value. No dependencies.
package teg_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Charset codes, shared by the fallback register and the result.
  localparam logic [2:0] CS_LATIN1 = 3'd0;
  localparam logic [2:0] CS_SJIS   = 3'd1;
  localparam logic [2:0] CS_UTF8   = 3'd2;
  localparam logic [2:0] CS_EUCJP  = 3'd3;
  localparam logic [2:0] CS_OTHER  = 3'd4;

  // Byte constants.
  localparam logic [7:0] BOM_B0     = 8'hEF;
  localparam logic [7:0] BOM_B1     = 8'hBB;
  localparam logic [7:0] BOM_B2     = 8'hBF;
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] NBSP       = 8'hA0;
  localparam logic [7:0] LAT_LETTER = 8'hC0;
  localparam logic [7:0] LAT_TIMES  = 8'hD7;
  localparam logic [7:0] LAT_DIVIDE = 8'hF7;
  localparam logic [7:0] SJ_TRAIL_LO = 8'h40;
  localparam logic [7:0] SJ_TRAIL_HI = 8'hFC;
  localparam logic [7:0] SJ_LEAD_HI  = 8'hEF;
  localparam logic [7:0] SJ_KANA_END = 8'hE0;
  localparam logic [7:0] SJ_C1_GAP   = 8'h80;
  localparam logic [7:0] CTRL_END    = 8'h20;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam logic [1:0] RUN_MAX = 2'd3;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] bytes_seen;
    logic                   bom_prefix_ok;
    logic                   utf8_valid;
    logic                   latin1_valid;
    logic                   sjis_valid;
    logic [1:0]             utf8_pending;
    logic                   utf8_multibyte_seen;
    logic                   sjis_pending;
    logic [1:0]             katakana_total;
    logic [1:0]             katakana_run;
    logic [1:0]             katakana_run_max;
    logic [1:0]             double_run;
    logic [1:0]             double_run_max;
    logic [COUNT_WIDTH-1:0] latin1_high_other;
  } teg_state_t;

  // Candidate flags at the end of a message.
  typedef struct packed {
    logic u8;
    logic sj;
    logic l1;
  } teg_cand_t;

  localparam teg_state_t STATE_CLEAR = '{
    bytes_seen:          '0,
    bom_prefix_ok:       1'b1,
    utf8_valid:          1'b1,
    latin1_valid:        1'b1,
    sjis_valid:          1'b1,
    utf8_pending:        2'd0,
    utf8_multibyte_seen: 1'b0,
    sjis_pending:        1'b0,
    katakana_total:      2'd0,
    katakana_run:        2'd0,
    katakana_run_max:    2'd0,
    double_run:          2'd0,
    double_run_max:      2'd0,
    latin1_high_other:   '0
  };

endpackage

### design/teg_scan.sv
// Next-state logic for one message byte: BOM check, UTF-8, Latin-1 and
// Shift-JIS validity tracking, runs and counters. Depends on teg_pkg.
module teg_scan
  import teg_pkg::*;
(
  input  teg_state_t st,
  input  logic [7:0] byte_value,
  output teg_state_t nx
);

  function automatic logic [1:0] sat3_inc(input logic [1:0] v);
    return (v == RUN_MAX) ? RUN_MAX : v + 2'd1;
  endfunction

  logic [7:0] bom_byte;
  logic       any_valid;

  always_comb begin
    case (st.bytes_seen[1:0])
      2'd0:    bom_byte = BOM_B0;
      2'd1:    bom_byte = BOM_B1;
      default: bom_byte = BOM_B2;
    endcase
  end

  assign any_valid = st.utf8_valid | st.latin1_valid | st.sjis_valid;

  always_comb begin
    nx = st;

    if (st.bytes_seen < COUNT_WIDTH'(3) && byte_value != bom_byte) begin
      nx.bom_prefix_ok = 1'b0;
    end

    // UTF-8
    if (any_valid && st.utf8_valid) begin
      if (st.utf8_pending != 2'd0) begin
        if (!byte_value[7]) nx.utf8_valid = 1'b0;
        else nx.utf8_pending = st.utf8_pending - 2'd1;
      end else if (byte_value[7]) begin
        if (!byte_value[6]) begin
          nx.utf8_valid = 1'b0;
        end else if (!byte_value[5]) begin
          nx.utf8_pending = 2'd1;
          nx.utf8_multibyte_seen = 1'b1;
        end else if (!byte_value[4]) begin
          nx.utf8_pending = 2'd2;
          nx.utf8_multibyte_seen = 1'b1;
        end else if (!byte_value[3]) begin
          nx.utf8_pending = 2'd3;
          nx.utf8_multibyte_seen = 1'b1;
        end else begin
          nx.utf8_valid = 1'b0;
        end
      end
    end

    // Latin-1
    if (any_valid && st.latin1_valid) begin
      if (byte_value > ASCII_MAX && byte_value < NBSP) begin
        nx.latin1_valid = 1'b0;
      end else if (byte_value >= NBSP) begin
        if ((byte_value < LAT_LETTER || byte_value == LAT_TIMES ||
             byte_value == LAT_DIVIDE) && st.latin1_high_other != COUNT_MAX) begin
          nx.latin1_high_other = st.latin1_high_other + COUNT_WIDTH'(1);
        end
      end
    end

    // Shift-JIS
    if (any_valid && st.sjis_valid) begin
      if (st.sjis_pending) begin
        if (byte_value < SJ_TRAIL_LO || byte_value == ASCII_MAX ||
            byte_value > SJ_TRAIL_HI) begin
          nx.sjis_valid = 1'b0;
        end else begin
          nx.sjis_pending = 1'b0;
        end
      end else if (byte_value == SJ_C1_GAP || byte_value == NBSP ||
                   byte_value > SJ_LEAD_HI) begin
        nx.sjis_valid = 1'b0;
      end else if (byte_value < CTRL_END && byte_value != CHAR_LF &&
                   byte_value != CHAR_CR) begin
        nx.sjis_valid = 1'b0;
      end else if (byte_value > NBSP && byte_value < SJ_KANA_END) begin
        nx.katakana_total = sat3_inc(st.katakana_total);
        nx.double_run     = 2'd0;
        nx.katakana_run   = sat3_inc(st.katakana_run);
        if (nx.katakana_run > st.katakana_run_max) nx.katakana_run_max = nx.katakana_run;
      end else if (byte_value > ASCII_MAX) begin
        nx.sjis_pending = 1'b1;
        nx.katakana_run = 2'd0;
        nx.double_run   = sat3_inc(st.double_run);
        if (nx.double_run > st.double_run_max) nx.double_run_max = nx.double_run;
      end else begin
        nx.katakana_run = 2'd0;
        nx.double_run   = 2'd0;
      end
    end

    if (st.bytes_seen != COUNT_MAX) begin
      nx.bytes_seen = st.bytes_seen + COUNT_WIDTH'(1);
    end
  end

endmodule

### design/teg_decide.sv
// Decision logic for the final byte: applies the charset priority order to
// the updated tracking state. Depends on teg_pkg.
module teg_decide
  import teg_pkg::*;
(
  input  teg_state_t st,
  input  teg_cand_t  cand,
  input  logic [2:0] fallback_charset,
  output logic [2:0] charset
);

  logic [2:0]             fb;
  logic                   bom;
  logic                   assume_sjis;
  logic                   kat2;
  logic                   many_high;
  logic [COUNT_WIDTH+3:0] high_x10;

  assign fb          = (fallback_charset > CS_OTHER) ? CS_OTHER : fallback_charset;
  assign bom         = st.bom_prefix_ok && st.bytes_seen > COUNT_WIDTH'(3);
  assign assume_sjis = (fb == CS_SJIS) || (fb == CS_EUCJP);
  assign kat2        = (st.katakana_run_max == 2'd2) && (st.katakana_total == 2'd2);
  // x*10 as x*8 + x*2
  assign high_x10    = {1'b0, st.latin1_high_other, 3'b000}
                     + {3'b000, st.latin1_high_other, 1'b0};
  assign many_high   = high_x10 >= {4'b0000, st.bytes_seen};

  always_comb begin
    if (cand.u8 && (bom || st.utf8_multibyte_seen)) begin
      charset = CS_UTF8;
    end else if (cand.sj && (assume_sjis || st.katakana_run_max == RUN_MAX ||
                             st.double_run_max == RUN_MAX)) begin
      charset = CS_SJIS;
    end else if (cand.l1 && cand.sj) begin
      charset = (kat2 || many_high) ? CS_SJIS : CS_LATIN1;
    end else if (cand.l1) begin
      charset = CS_LATIN1;
    end else if (cand.sj) begin
      charset = CS_SJIS;
    end else if (cand.u8) begin
      charset = CS_UTF8;
    end else begin
      charset = fb;
    end
  end

endmodule

### design/text_encoding_guesser_core.sv
// Text encoding guesser core. Feed a message one byte per input transaction,
// with in_last_byte high on its final byte; that byte produces one result
// transaction giving the guessed charset (0 latin1, 1 sjis, 2 utf8,
// 3 euc_jp, 4 other) and whether the message stayed valid UTF-8, Shift-JIS
// and ISO-8859-1 to the end. Other bytes produce no result. The block takes
// one byte every cycle unless a last byte waits for the output register:
// each byte passes an input register and then a single state-update stage
// that advances all candidate trackers at once; a last byte also loads its
// result into the output register, which drives out_valid. A result held in
// the output register waits for out_ready while following bytes are still
// taken; only a further last byte stalls until the register frees.
// Tracking state is cleared after every last byte. cfg_fallback_charset
// selects the answer when nothing fits (values above 4 act as 4) and a
// Shift-JIS or EUC-JP fallback biases the choice toward Shift-JIS; write it
// only between messages.
module text_encoding_guesser_core
  import teg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_fallback_charset,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_byte,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_charset,
  output logic       out_utf8_possible,
  output logic       out_sjis_possible,
  output logic       out_latin1_possible
);

  // Configuration register
  logic [2:0] fallback_r;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Tracking state
  teg_state_t state_r;
  teg_state_t state_nxt;
  teg_state_t scan_nx;

  // Result register
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] charset_r;
  teg_cand_t  cand_r;

  teg_cand_t  cand;
  logic [2:0] charset;
  logic       s1_go;
  logic       out_load;

  // Accept configuration at any time; the user keeps it to idle periods.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= CS_LATIN1;
    end else if (cfg_valid) begin
      fallback_r <= cfg_fallback_charset;
    end
  end

  // A byte in the input register may advance unless it is a last byte
  // and the result register is still occupied by an untaken transaction.
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign out_load = s1_go && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  teg_scan u_scan (
    .st         (state_r),
    .byte_value (s1_byte_r),
    .nx         (scan_nx)
  );

  // Unfinished multi-byte sequences count as invalid at the end.
  assign cand.u8 = scan_nx.utf8_valid && (scan_nx.utf8_pending == 2'd0);
  assign cand.sj = scan_nx.sjis_valid && !scan_nx.sjis_pending;
  assign cand.l1 = scan_nx.latin1_valid;

  teg_decide u_decide (
    .st               (scan_nx),
    .cand             (cand),
    .fallback_charset (fallback_r),
    .charset          (charset)
  );

  // Advance the trackers on every byte; clear them after a last byte.
  always_comb begin
    state_nxt = state_r;
    if (s1_go) begin
      state_nxt = s1_last_r ? STATE_CLEAR : scan_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result register: load on a last byte, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      charset_r <= charset;
      cand_r    <= cand;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_charset         = charset_r;
  assign out_utf8_possible   = cand_r.u8;
  assign out_sjis_possible   = cand_r.sj;
  assign out_latin1_possible = cand_r.l1;

endmodule

### design/teg_checker.sv
// Port-level checks for text_encoding_guesser_core, attached by the bind
// at the end of this file. Depends on teg_pkg.
module teg_checker
  import teg_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_charset,
  input logic       out_utf8_possible,
  input logic       out_sjis_possible,
  input logic       out_latin1_possible
);

  logic any_possible;
  assign any_possible = out_utf8_possible | out_sjis_possible | out_latin1_possible;

  // No result straight out of reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_charset) &&
      $stable(out_latin1_possible) && $stable(out_utf8_possible))
    else $error("stalled result changed");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charset <= CS_OTHER)
    else $error("charset code out of range");

  // Latin-1 or UTF-8 chosen while some candidate fits implies that one fits.
  a_latin1_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && any_possible && out_charset == CS_LATIN1 |-> out_latin1_possible)
    else $error("latin1 chosen but not possible");

  a_utf8_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && any_possible && out_charset == CS_UTF8 |-> out_utf8_possible)
    else $error("utf8 chosen but not possible");

endmodule

bind text_encoding_guesser_core teg_checker u_teg_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_charset         (out_charset),
  .out_utf8_possible   (out_utf8_possible),
  .out_sjis_possible   (out_sjis_possible),
  .out_latin1_possible (out_latin1_possible)
);

### tb/sv/text_encoding_guesser_core_tb.sv
// Self-checking testbench for text_encoding_guesser_core: directed, fallback
// and random messages are checked against a built-in charset predictor.
// Depends on teg_pkg and the text_encoding_guesser_core RTL only.
module text_encoding_guesser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import teg_pkg::*;

  // Cycles to wait after the last result before touching the register or
  // ending: input register, state stage and output register.
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_LIMIT  = 2000;

  // One expected result transaction.
  typedef struct packed {
    logic [2:0] charset;
    logic       utf8_ok;
    logic       sjis_ok;
    logic       latin1_ok;
  } guess_t;

  // Shapes of random message.
  typedef enum int {FL_UTF8, FL_SJIS, FL_LATIN1, FL_NOISE, FL_BROKEN} flavour_t;
  // Character classes inside a random message.
  typedef enum int {CH_ASCII, CH_PAIR, CH_TRIPLE, CH_QUAD} char_kind_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_fallback_charset;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte_value;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_charset;
  logic       out_utf8_possible;
  logic       out_sjis_possible;
  logic       out_latin1_possible;

  // Predictor copy of the tracking state and the fallback register.
  teg_state_t trk;
  logic [2:0] fallback_q;
  guess_t     expected_guesses[$];
  guess_t     want;
  logic [7:0] msg_bytes[$];

  int err_count    = 0;
  int results_seen = 0;
  int bytes_sent   = 0;
  int msgs_sent    = 0;
  int cfg_writes   = 0;
  int burst_left   = 0;
  int stall_mode   = 0;
  int mode_left    = 0;
  int charset_hits[8];

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_encoding_guesser_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_fallback_charset (cfg_fallback_charset),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte_value        (in_byte_value),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_charset          (out_charset),
    .out_utf8_possible    (out_utf8_possible),
    .out_sjis_possible    (out_sjis_possible),
    .out_latin1_possible  (out_latin1_possible)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [1:0] sat_run(input logic [1:0] x);
    return (x >= RUN_MAX) ? RUN_MAX : x + 2'd1;
  endfunction

  function automatic logic [7:0] rnd_byte(input int lo, input int hi);
    logic [7:0] b;
    b = 8'($urandom_range(hi, lo));
    return b;
  endfunction

  // Append one byte to the message under construction.
  function automatic void add_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  // Advance the tracking state by one accepted byte; on the last byte of a
  // message queue the expected guess and clear the state.
  function automatic void track_byte(input logic [7:0] v, input logic last);
    guess_t      g;
    logic        u8;
    logic        sj;
    logic        l1;
    logic        bom;
    logic        kat2;
    logic        many_high;
    logic [2:0]  fb;
    int unsigned high_cnt;
    int unsigned seen_cnt;

    // The first three bytes must spell the UTF-8 byte order mark.
    if ((trk.bytes_seen == 0 && v != BOM_B0) || (trk.bytes_seen == 1 && v != BOM_B1) ||
        (trk.bytes_seen == 2 && v != BOM_B2))
      trk.bom_prefix_ok = 1'b0;

    // Once every candidate has failed, freeze the candidate trackers.
    if (trk.utf8_valid || trk.latin1_valid || trk.sjis_valid) begin
      if (trk.utf8_valid) begin
        if (trk.utf8_pending != 2'd0) begin
          if (!v[7])
            trk.utf8_valid = 1'b0;
          else
            trk.utf8_pending = trk.utf8_pending - 2'd1;
        end else if (v[7]) begin
          if (!v[6]) begin
            trk.utf8_valid = 1'b0;
          end else if (!v[5]) begin
            trk.utf8_pending = 2'd1;
            trk.utf8_multibyte_seen = 1'b1;
          end else if (!v[4]) begin
            trk.utf8_pending = 2'd2;
            trk.utf8_multibyte_seen = 1'b1;
          end else if (!v[3]) begin
            trk.utf8_pending = 2'd3;
            trk.utf8_multibyte_seen = 1'b1;
          end else begin
            trk.utf8_valid = 1'b0;
          end
        end
      end

      if (trk.latin1_valid) begin
        if (v > ASCII_MAX && v < NBSP)
          trk.latin1_valid = 1'b0;
        else if (v >= NBSP && (v < LAT_LETTER || v == LAT_TIMES || v == LAT_DIVIDE) &&
                 trk.latin1_high_other != COUNT_MAX)
          trk.latin1_high_other = trk.latin1_high_other + COUNT_WIDTH'(1);
      end

      if (trk.sjis_valid) begin
        if (trk.sjis_pending) begin
          if (v < SJ_TRAIL_LO || v == ASCII_MAX || v > SJ_TRAIL_HI)
            trk.sjis_valid = 1'b0;
          else
            trk.sjis_pending = 1'b0;
        end else if (v == SJ_C1_GAP || v == NBSP || v > SJ_LEAD_HI) begin
          trk.sjis_valid = 1'b0;
        end else if (v < CTRL_END && v != CHAR_LF && v != CHAR_CR) begin
          trk.sjis_valid = 1'b0;
        end else if (v > NBSP && v < SJ_KANA_END) begin
          // half-width katakana
          trk.katakana_total = sat_run(trk.katakana_total);
          trk.double_run     = 2'd0;
          trk.katakana_run   = sat_run(trk.katakana_run);
          if (trk.katakana_run > trk.katakana_run_max)
            trk.katakana_run_max = trk.katakana_run;
        end else if (v > ASCII_MAX) begin
          // lead byte of a double-byte character
          trk.sjis_pending = 1'b1;
          trk.katakana_run = 2'd0;
          trk.double_run   = sat_run(trk.double_run);
          if (trk.double_run > trk.double_run_max)
            trk.double_run_max = trk.double_run;
        end else begin
          trk.katakana_run = 2'd0;
          trk.double_run   = 2'd0;
        end
      end
    end

    if (trk.bytes_seen != COUNT_MAX)
      trk.bytes_seen = trk.bytes_seen + COUNT_WIDTH'(1);

    if (last) begin
      u8 = trk.utf8_valid && trk.utf8_pending == 2'd0;
      sj = trk.sjis_valid && !trk.sjis_pending;
      l1 = trk.latin1_valid;
      fb = (fallback_q > CS_OTHER) ? CS_OTHER : fallback_q;
      bom = trk.bom_prefix_ok && trk.bytes_seen > 3;
      kat2 = trk.katakana_run_max == 2'd2 && trk.katakana_total == 2'd2;
      high_cnt = 32'(trk.latin1_high_other);
      seen_cnt = 32'(trk.bytes_seen);
      many_high = high_cnt * 10 >= seen_cnt;

      if (u8 && (bom || trk.utf8_multibyte_seen))
        g.charset = CS_UTF8;
      else if (sj && (fb == CS_SJIS || fb == CS_EUCJP || trk.katakana_run_max == RUN_MAX ||
                      trk.double_run_max == RUN_MAX))
        g.charset = CS_SJIS;
      else if (l1 && sj)
        g.charset = (kat2 || many_high) ? CS_SJIS : CS_LATIN1;
      else if (l1)
        g.charset = CS_LATIN1;
      else if (sj)
        g.charset = CS_SJIS;
      else if (u8)
        g.charset = CS_UTF8;
      else
        g.charset = fb;

      g.utf8_ok   = u8;
      g.sjis_ok   = sj;
      g.latin1_ok = l1;
      expected_guesses.insert(expected_guesses.size(), g);
      trk = STATE_CLEAR;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Send one byte transaction. The sender runs in bursts; between bursts it
  // idles for a random gap, sometimes none at all.
  task automatic send_byte(input logic [7:0] v, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_byte_value <= v;
    in_last_byte  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_byte(v, last);
    bytes_sent++;
    if (last)
      msgs_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Send msg_bytes as one message, marking its final byte, then drop it.
  task automatic send_msg();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  // Write the fallback register once the block has gone idle.
  task automatic write_fallback(input logic [2:0] val);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_guesses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_fallback_charset <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fallback_q = val;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: out_ready follows a randomly chosen mode that changes now and then,
  // from always ready through random and periodic stalls to long holds.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (mode_left % 4 == 3);
      default: out_ready <= (mode_left % 25 < 5);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every result transaction with the oldest guess
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_guesses.size() == 0) begin
        report_error($sformatf("result with nothing expected: charset=%0d u8=%b sj=%b l1=%b",
                               out_charset, out_utf8_possible, out_sjis_possible,
                               out_latin1_possible));
      end else begin
        want = expected_guesses.pop_front();
        charset_hits[want.charset]++;
        if (out_charset !== want.charset || out_utf8_possible !== want.utf8_ok ||
            out_sjis_possible !== want.sjis_ok || out_latin1_possible !== want.latin1_ok)
          report_error($sformatf(
            "result %0d: expected charset=%0d u8=%b sj=%b l1=%b, got charset=%0d u8=%b sj=%b l1=%b",
            results_seen, want.charset, want.utf8_ok, want.sjis_ok, want.latin1_ok,
            out_charset, out_utf8_possible, out_sjis_possible, out_latin1_possible));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-picked messages covering branches of the decision.
  task automatic test_directed();
    write_fallback(CS_LATIN1);
    msg_bytes = '{BOM_B0, BOM_B1, BOM_B2, 8'h41};    // byte order mark, then text
    send_msg();
    msg_bytes = '{8'hC3, 8'hA9};                      // two-byte UTF-8 character
    send_msg();
    msg_bytes = '{8'hE2, 8'h82};                      // UTF-8 cut short at the end
    send_msg();
    msg_bytes = '{8'hB1, 8'hB2, 8'hB3};               // katakana run of three
    send_msg();
    msg_bytes = '{8'h81, 8'h40};                      // one double-byte character
    send_msg();
    msg_bytes = '{8'h00};                             // lowest byte
    send_msg();
    msg_bytes = '{8'hFF};                             // highest byte: Latin-1 only
    send_msg();
    msg_bytes = '{8'h80};                             // nothing fits
    send_msg();
    msg_bytes = '{8'hB1, 8'hB2, 8'h41};               // exactly two katakana
    send_msg();
    msg_bytes = '{8'h81};                             // Shift-JIS lead left open
    send_msg();
  endtask

  // Every register value, including the out-of-range ones, against messages
  // that reach the fallback and the Shift-JIS bias.
  task automatic test_fallback_sweep();
    for (int f = 0; f < 8; f++) begin
      write_fallback(f[2:0]);
      msg_bytes = '{8'h80};
      send_msg();
      msg_bytes = '{8'h41, ASCII_MAX};
      send_msg();
      msg_bytes = '{8'hB1, 8'hB2, 8'h41};
      send_msg();
    end
  endtask

  // Build one random message in msg_bytes. Most are well formed in one of
  // the three schemes with random content; the rest are noise or broken.
  task automatic build_random_message();
    flavour_t   fl;
    char_kind_t kind;
    logic [7:0] b;
    logic       corrupt;
    int         pick;
    int         n_chars;
    int         reps;

    pick = $urandom_range(0, 9);
    fl = (pick < 3) ? FL_UTF8 : (pick < 6) ? FL_SJIS : (pick < 8) ? FL_LATIN1 :
         (pick == 8) ? FL_NOISE : FL_BROKEN;
    corrupt = (fl == FL_BROKEN);
    if (corrupt)
      fl = ($urandom_range(0, 1) == 0) ? FL_UTF8 : FL_SJIS;
    n_chars = $urandom_range(1, 8);

    if (fl == FL_UTF8 && $urandom_range(0, 3) == 0)
      msg_bytes = '{BOM_B0, BOM_B1, BOM_B2};

    for (int c = 0; c < n_chars; c++) begin
      kind = char_kind_t'($urandom_range(0, 3));
      case (fl)
        FL_UTF8: begin
          case (kind)
            CH_ASCII:  add_byte(rnd_byte(8'h20, 8'h7E));
            CH_PAIR:   add_byte(rnd_byte(8'hC0, 8'hDF));
            CH_TRIPLE: add_byte(rnd_byte(8'hE0, 8'hEF));
            default:   add_byte(rnd_byte(8'hF0, 8'hF7));
          endcase
          for (int k = 0; k < int'(kind); k++)
            add_byte(rnd_byte(8'h80, 8'hBF));
        end
        FL_SJIS: begin
          // repeat a class so that runs of three show up
          reps = $urandom_range(1, 4);
          for (int r = 0; r < reps; r++) begin
            case (kind)
              CH_ASCII: begin
                b = rnd_byte(8'h20, 8'h7E);
                if ($urandom_range(0, 7) == 0)
                  b = ($urandom_range(0, 1) == 0) ? CHAR_LF : CHAR_CR;
                add_byte(b);
              end
              CH_PAIR: add_byte(rnd_byte(8'hA1, 8'hDF));
              default: begin
                add_byte(($urandom_range(0, 1) == 0) ? rnd_byte(8'h81, 8'h9F) :
                                                       rnd_byte(8'hE0, SJ_LEAD_HI));
                b = rnd_byte(SJ_TRAIL_LO, SJ_TRAIL_HI);
                add_byte((b == ASCII_MAX) ? SJ_C1_GAP : b);
              end
            endcase
          end
        end
        FL_LATIN1:
          add_byte((kind == CH_ASCII) ? rnd_byte(8'h20, 8'h7E) : rnd_byte(NBSP, 8'hFF));
        default:
          add_byte(rnd_byte(0, 255));
      endcase
    end

    // Break a well-formed message: cut its tail or overwrite one byte.
    if (corrupt) begin
      if (msg_bytes.size() > 1 && $urandom_range(0, 1) == 0)
        void'(msg_bytes.pop_back());
      else
        msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = rnd_byte(0, 255);
    end
  endtask

  // Random messages, with the register rewritten now and then between them.
  task automatic test_random(input int n_bytes);
    int         start;
    logic [2:0] val;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0)
          val = ($urandom_range(0, 1) == 0) ? CS_LATIN1 : 3'd7;
        else
          val = 3'($urandom_range(0, 7));
        write_fallback(val);
      end
      build_random_message();
      send_msg();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                = 1'b0;
    cfg_valid            = 1'b0;
    cfg_fallback_charset = CS_LATIN1;
    in_valid             = 1'b0;
    in_byte_value        = 8'h00;
    in_last_byte         = 1'b0;
    out_ready            = 1'b0;
    trk                  = STATE_CLEAR;
    fallback_q           = CS_LATIN1;
    foreach (charset_hits[i]) charset_hits[i] = 0;

    // hold reset, then release it on a falling edge
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_fallback_sweep();
    test_random(430);

    // stop sending, then drain the outstanding guesses
    in_valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && expected_guesses.size() != 0; w++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_guesses.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_guesses.size()));

    $display("Run covered %0d messages, %0d bytes, %0d results, %0d fallback writes",
             msgs_sent, bytes_sent, results_seen, cfg_writes);
    $display("Guesses: latin1 %0d, sjis %0d, utf8 %0d, euc_jp %0d, other %0d; errors %0d",
             charset_hits[CS_LATIN1], charset_hits[CS_SJIS], charset_hits[CS_UTF8],
             charset_hits[CS_EUCJP], charset_hits[CS_OTHER], err_count);
    if (err_count == 0)
      $display("text_encoding_guesser_core_tb passed");
    else
      $display("text_encoding_guesser_core_tb failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("text_encoding_guesser_core_tb failed");
    $finish;
  end

endmodule

### filelist.f
design/teg_pkg.sv
design/teg_scan.sv
design/teg_decide.sv
design/text_encoding_guesser_core.sv
design/teg_checker.sv
tb/sv/text_encoding_guesser_core_tb.sv
